// ===== hdl/lfu_pkg.sv =====
// Package for the least-frequently-used key-value cache.
// Holds command codes, cell operation codes and reset defaults.
// No dependencies.
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CMD_W  = 2;
    localparam int WORD_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Operation applied to one cell at the end of a transaction.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INC,
        ACT_LOAD,
        ACT_FREE
    } t_act;

endpackage

`default_nettype wire

// ===== hdl/lfu_cell.sv =====
// One storage cell of the cache chain: holds one entry and folds it into the
// search record that travels from cell to cell. Depends on lfu_pkg.
`default_nettype none

module lfu_cell #(
    parameter int  ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int  COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
    parameter int  CELL_INDEX = 0,
    parameter type t_probe    = logic
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  [lfu_pkg::WORD_W-1:0]       i_key,
    input  wire  [lfu_pkg::WORD_W-1:0]       i_data,
    input  wire  [lfu_pkg::WORD_W-1:0]       i_size,
    input  lfu_pkg::t_act                    i_act_op,
    input  wire  [$clog2(ENTRIES)-1:0]       i_act_idx,
    input  t_probe                           i_probe,
    output t_probe                           o_probe,
    output logic                             o_valid
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int NVW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);

    logic                         r_valid;
    logic [lfu_pkg::WORD_W-1:0]   r_key;
    logic [lfu_pkg::WORD_W-1:0]   r_data;
    logic [lfu_pkg::WORD_W-1:0]   r_size;
    logic [COUNT_BITS-1:0]        r_count;
    t_probe                       r_probe;
    t_probe                       n_probe;
    logic                         w_hit;
    logic                         w_sel;

    assign w_hit = r_valid && (r_key == i_key);
    assign w_sel = (i_act_idx == MY_IDX);

    always_comb begin
        n_probe = i_probe;
        if (w_hit && !i_probe.hit) begin
            n_probe.hit      = 1'b1;
            n_probe.hit_idx  = MY_IDX;
            n_probe.hit_data = r_data;
            n_probe.hit_size = r_size;
        end
        if (!r_valid && !i_probe.free) begin
            n_probe.free     = 1'b1;
            n_probe.free_idx = MY_IDX;
        end
        // Strict compare keeps the lowest index on a tie.
        if (r_valid && (!i_probe.have_min || (r_count < i_probe.min_cnt))) begin
            n_probe.have_min = 1'b1;
            n_probe.min_cnt  = r_count;
            n_probe.min_idx  = MY_IDX;
        end
        n_probe.nvalid = i_probe.nvalid + NVW'(r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            case (i_act_op)
                lfu_pkg::ACT_INC: begin
                    if (r_count != {COUNT_BITS{1'b1}}) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                lfu_pkg::ACT_LOAD: begin
                    r_valid <= 1'b1;
                    r_key   <= i_key;
                    r_data  <= i_data;
                    r_size  <= i_size;
                    r_count <= '0;
                end
                lfu_pkg::ACT_FREE: begin
                    r_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_probe = r_probe;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// ===== hdl/lfu_key_value_cache.sv =====
// The block takes one command at a time and takes no new one while busy. The command
// and a launch flag are registered; the search record walks the cell chain one cell per
// cycle, then the update is applied and the result is registered, and busy is
// low during the strobe cycle so the next transaction is taken at the edge that ends it.
// The receiver cannot stall; o_done is high for exactly one cycle per command.
// Synchronous active-low reset empties every entry and sets capacity to 16.
`default_nettype none

module lfu_key_value_cache #(
    parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
    parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [lfu_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  wire                               i_start,
    output logic                              o_busy,
    input  wire  [lfu_pkg::CMD_W-1:0]         i_command,
    input  wire  [lfu_pkg::WORD_W-1:0]        i_key,
    input  wire  [lfu_pkg::WORD_W-1:0]        i_write_data,
    input  wire  [lfu_pkg::WORD_W-1:0]        i_write_size,
    output logic                              o_done,
    output logic                              o_found,
    output logic [lfu_pkg::WORD_W-1:0]        o_read_data,
    output logic [lfu_pkg::WORD_W-1:0]        o_read_size
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int NVW = $clog2(ENTRIES + 1);
    localparam int CW  = (NVW > lfu_pkg::CAP_W) ? NVW : lfu_pkg::CAP_W;

    typedef struct packed {
        logic                         active;
        logic                         hit;
        logic [IW-1:0]                hit_idx;
        logic [lfu_pkg::WORD_W-1:0]   hit_data;
        logic [lfu_pkg::WORD_W-1:0]   hit_size;
        logic                         free;
        logic [IW-1:0]                free_idx;
        logic                         have_min;
        logic [COUNT_BITS-1:0]        min_cnt;
        logic [IW-1:0]                min_idx;
        logic [NVW-1:0]               nvalid;
    } t_probe;

    logic                         r_busy;
    logic                         r_launch;
    logic [lfu_pkg::CMD_W-1:0]    r_cmd;
    logic [lfu_pkg::WORD_W-1:0]   r_key;
    logic [lfu_pkg::WORD_W-1:0]   r_wdata;
    logic [lfu_pkg::WORD_W-1:0]   r_wsize;
    logic [lfu_pkg::CAP_W-1:0]    r_capacity;
    logic                         r_done;
    logic                         r_found;
    logic [lfu_pkg::WORD_W-1:0]   r_rdata;
    logic [lfu_pkg::WORD_W-1:0]   r_rsize;

    t_probe                       w_chain [0:ENTRIES];
    logic   [ENTRIES-1:0]         w_valid;
    t_probe                       w_last;
    lfu_pkg::t_act                w_act_op;
    logic   [IW-1:0]              w_act_idx;
    logic                         w_found;
    logic   [lfu_pkg::WORD_W-1:0] w_rdata;
    logic   [lfu_pkg::WORD_W-1:0] w_rsize;
    logic   [CW-1:0]              w_cap_ext;
    logic   [CW-1:0]              w_cap_eff;
    logic                         w_room;
    logic   [IW-1:0]              w_slot;
    logic                         w_accept;

    assign w_accept = i_start && !r_busy;

    always_comb begin
        w_chain[0]        = '0;
        w_chain[0].active = r_launch;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .ENTRIES    (ENTRIES),
            .COUNT_BITS (COUNT_BITS),
            .CELL_INDEX (g),
            .t_probe    (t_probe)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_key     (r_key),
            .i_data    (r_wdata),
            .i_size    (r_wsize),
            .i_act_op  (w_act_op),
            .i_act_idx (w_act_idx),
            .i_probe   (w_chain[g]),
            .o_probe   (w_chain[g+1]),
            .o_valid   (w_valid[g])
        );
    end

    assign w_last = w_chain[ENTRIES];

    // Capacity in effect is clamped to the range 1 to ENTRIES.
    always_comb begin
        w_cap_ext = CW'(r_capacity);
        if (w_cap_ext == '0) begin
            w_cap_eff = CW'(1);
        end else if (w_cap_ext > CW'(ENTRIES)) begin
            w_cap_eff = CW'(ENTRIES);
        end else begin
            w_cap_eff = w_cap_ext;
        end
        w_room = CW'(w_last.nvalid) < w_cap_eff;
        if (w_room && w_last.free) begin
            w_slot = w_last.free_idx;
        end else if (w_last.have_min) begin
            w_slot = w_last.min_idx;
        end else begin
            w_slot = '0;
        end
    end

    always_comb begin
        w_act_op  = lfu_pkg::ACT_NONE;
        w_act_idx = w_last.hit_idx;
        w_found   = 1'b0;
        w_rdata   = '0;
        w_rsize   = '0;
        case (r_cmd)
            lfu_pkg::CMD_GET: begin
                if (w_last.hit) begin
                    w_act_op = lfu_pkg::ACT_INC;
                    w_found  = 1'b1;
                    w_rdata  = w_last.hit_data;
                    w_rsize  = w_last.hit_size;
                end
            end
            lfu_pkg::CMD_WRITE: begin
                w_act_op = lfu_pkg::ACT_LOAD;
                w_found  = w_last.hit;
                if (!w_last.hit) begin
                    w_act_idx = w_slot;
                end
            end
            lfu_pkg::CMD_REMOVE: begin
                if (w_last.hit) begin
                    w_act_op = lfu_pkg::ACT_FREE;
                    w_found  = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (!w_last.active) begin
            w_act_op = lfu_pkg::ACT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_command;
            r_key   <= i_key;
            r_wdata <= i_write_data;
            r_wsize <= i_write_size;
        end
        r_found <= w_found;
        r_rdata <= w_rdata;
        r_rsize <= w_rsize;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_launch   <= 1'b0;
            r_done     <= 1'b0;
            r_capacity <= lfu_pkg::CAP_RESET;
        end else begin
            r_launch <= w_accept;
            r_done   <= w_last.active;
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_last.active) begin
                r_busy <= 1'b0;
            end
            if (i_cfg_we && !(|w_valid)) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_found     = r_found;
    assign o_read_data = r_rdata;
    assign o_read_size = r_rsize;

endmodule

`default_nettype wire

// ===== hdl/lfu_checker.sv =====
// Port-level checker for the cache, attached to the top level by bind.
// Depends on lfu_pkg and lfu_key_value_cache.
`default_nettype none

module lfu_checker #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_start,
    input wire                           o_busy,
    input wire                           o_done,
    input wire                           o_found,
    input wire [lfu_pkg::WORD_W-1:0]     o_read_data,
    input wire [lfu_pkg::WORD_W-1:0]     o_read_size
);

    // Every accepted transaction produces a result strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(ENTRIES + 2) o_done)
        else $error("result strobe missing after accepted transaction");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy did not rise after an accepted transaction");

    a_done_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_busy && $past(o_busy)))
        else $error("result strobe not aligned with end of busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_read_data == '0 && o_read_size == '0))
        else $error("nonzero read data on a miss");

endmodule

bind lfu_key_value_cache lfu_checker #(.ENTRIES(ENTRIES)) u_lfu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_done      (o_done),
    .o_found     (o_found),
    .o_read_data (o_read_data),
    .o_read_size (o_read_size)
);

`default_nettype wire
